@@ rtl/bsm_pkg.sv @@
// package for the bytecode stack machine core: word types, codes, state encoding
// depends on nothing; used by bytecode_stack_machine_core
package bsm_pkg;

	localparam int PC_BITS = 14;

	typedef enum logic [1:0] {
		MODE_EXEC    = 2'd0,
		MODE_READ    = 2'd1,
		MODE_RESTART = 2'd2
	} mode_t;

	typedef enum logic [7:0] {
		OP_NOP   = 8'd0,
		OP_FETCH = 8'd1,
		OP_STORE = 8'd2,
		OP_LIT1  = 8'd3,
		OP_LIT2  = 8'd4,
		OP_LIT4  = 8'd5,
		OP_DROP  = 8'd6,
		OP_ADD   = 8'd7,
		OP_SUB   = 8'd8,
		OP_MUL   = 8'd9,
		OP_DIV   = 8'd10,
		OP_LT    = 8'd11,
		OP_GT    = 8'd12,
		OP_EQ    = 8'd13,
		OP_JZ    = 8'd14,
		OP_JNZ   = 8'd15,
		OP_JMP   = 8'd16,
		OP_CALL  = 8'd17,
		OP_RET   = 8'd18,
		OP_HALT  = 8'd19
	} op_t;

	typedef enum logic [3:0] {
		STAT_OK       = 4'd0,
		STAT_HALT     = 4'd1,
		STAT_EMPTYRET = 4'd2,
		STAT_BADOP    = 4'd3,
		STAT_DIVZERO  = 4'd4,
		STAT_OVER     = 4'd5,
		STAT_UNDER    = 4'd6,
		STAT_RETOVER  = 4'd7,
		STAT_BADIDX   = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_EXE,
		ST_MUL,
		ST_DIV,
		ST_WB,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         opcode;
		logic signed [31:0] operand;
	} cmd_word_t;

	typedef struct packed {
		logic [PC_BITS-1:0] next_pc;
		logic               halted;
		logic [3:0]         status;
		logic signed [63:0] top_value;
		logic signed [63:0] read_value;
	} res_word_t;

endpackage

@@ rtl/bsm_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// depends on nothing
module bsm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/bytecode_stack_machine_core.sv @@
// bytecode stack machine core: one instruction (or read / restart) per command word
// a word passes accept, execute and done; add, sub and compares add a write-back state,
// mul runs 4 partial products of 64x16 before write-back, div runs radix-2 restoring
// (one quotient bit a cycle) before write-back; one word in flight at a time
// after reset a clearing pass zeroes the value store, with cmd_ready low
// depends on bsm_pkg and bsm_ram
module bytecode_stack_machine_core
	import bsm_pkg::*;
#(
	parameter int STACK_DEPTH  = 128,
	parameter int RETURN_DEPTH = 1024,
	parameter int VALUE_SLOTS  = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_word_t cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output res_word_t res
);
	// address and depth widths
	localparam int DS_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DD_W  = $clog2(STACK_DEPTH + 1);
	localparam int RS_AW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
	localparam int RD_W  = $clog2(RETURN_DEPTH + 1);
	localparam int VS_AW = (VALUE_SLOTS > 1) ? $clog2(VALUE_SLOTS) : 1;

	// control state
	st_t               st_q, st_d;
	logic [PC_BITS-1:0] pc_q, pc_d;
	logic [DD_W-1:0]   dd_q, dd_d;
	logic [RD_W-1:0]   rdp_q, rdp_d;
	logic              stop_q, stop_d;
	logic [VS_AW-1:0]  clr_q;
	logic              res_valid_q;
	res_word_t         res_q;

	// captured command word and step results
	logic [1:0]        mode_q;
	logic [7:0]        op_q;
	logic [31:0]       opr_q;
	logic [63:0]       top_q, top_d;
	logic [3:0]        status_q, status_d;
	logic [63:0]       rdval_q, rdval_d;
	logic [63:0]       arith_q, arith_d;

	// iterative units: multiplier and divider share the step counter
	logic [5:0]        itcnt_q, itcnt_d;
	logic [63:0]       ma_q, ma_d, mb_q, mb_d, macc_q, macc_d;
	logic [63:0]       dvd_q, dvd_d, rem_q, rem_d, dvs_q, dvs_d;
	logic              dneg_q, dneg_d;
	logic [79:0]       mprod;
	logic [64:0]       dtrial, dshift;
	logic [63:0]       macc_nx, dvd_nx, ua, ub;

	// memory ports
	logic              acc;
	logic              ds_we, rs_we, vs_we;
	logic [DS_AW-1:0]  ds_waddr, ds_raddr;
	logic [63:0]       ds_wdata, ds_rdata;
	logic [RS_AW-1:0]  rs_waddr, rs_raddr;
	logic [PC_BITS-1:0] rs_wdata, rs_rdata;
	logic [VS_AW-1:0]  vs_waddr;
	logic [63:0]       vs_wdata, vs_rdata;
	logic [DD_W-1:0]   dd_m2;
	logic [RD_W-1:0]   rdp_m1;

	// decode helpers
	logic [15:0]       imm16;
	logic              idx_bad, ds_full, rs_full;
	logic [PC_BITS-1:0] target, pc1, pc2, pc3, pc5;

	assign acc       = cmd_valid && cmd_ready;
	assign cmd_ready = (st_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// reads are issued at accept from the current depths; data is ready in ST_EXE
	assign dd_m2    = dd_q - DD_W'(2);
	assign rdp_m1   = rdp_q - RD_W'(1);
	assign ds_raddr = dd_m2[DS_AW-1:0];
	assign rs_raddr = rdp_m1[RS_AW-1:0];

	bsm_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_data_stack (
		.clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
		.re(acc), .raddr(ds_raddr), .rdata(ds_rdata)
	);

	bsm_ram #(.WIDTH(PC_BITS), .DEPTH(RETURN_DEPTH)) u_return_stack (
		.clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
		.re(acc), .raddr(rs_raddr), .rdata(rs_rdata)
	);

	// fetch, store and read mode all index with the low operand bits
	bsm_ram #(.WIDTH(64), .DEPTH(VALUE_SLOTS)) u_value_store (
		.clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
		.re(acc), .raddr(cmd.operand[VS_AW-1:0]), .rdata(vs_rdata)
	);

	assign imm16   = opr_q[15:0];
	assign idx_bad = imm16[15] || ({16'd0, imm16} >= 32'(VALUE_SLOTS));
	assign ds_full = (dd_q >= DD_W'(STACK_DEPTH));
	assign rs_full = (rdp_q >= RD_W'(RETURN_DEPTH));
	assign target  = imm16[PC_BITS-1:0];
	assign pc1     = pc_q + PC_BITS'(1);
	assign pc2     = pc_q + PC_BITS'(2);
	assign pc3     = pc_q + PC_BITS'(3);
	assign pc5     = pc_q + PC_BITS'(5);

	// one 64x16 partial product per step, low 64 bits kept
	assign mprod   = ma_q * mb_q[15:0];
	assign macc_nx = macc_q + mprod[63:0];

	// restoring division step on magnitudes
	assign dshift = {rem_q, dvd_q[63]};
	assign dtrial = dshift - {1'b0, dvs_q};
	assign dvd_nx = {dvd_q[62:0], ~dtrial[64]};

	// operand magnitudes: a is second from top (memory), b is the cached top
	assign ua = ds_rdata[63] ? (64'd0 - ds_rdata) : ds_rdata;
	assign ub = top_q[63] ? (64'd0 - top_q) : top_q;

	always_comb begin
		st_d     = st_q;
		pc_d     = pc_q;
		dd_d     = dd_q;
		rdp_d    = rdp_q;
		stop_d   = stop_q;
		top_d    = top_q;
		status_d = status_q;
		rdval_d  = rdval_q;
		arith_d  = arith_q;
		itcnt_d  = itcnt_q;
		ma_d     = ma_q;
		mb_d     = mb_q;
		macc_d   = macc_q;
		dvd_d    = dvd_q;
		rem_d    = rem_q;
		dvs_d    = dvs_q;
		dneg_d   = dneg_q;
		ds_we    = 1'b0;
		ds_waddr = dd_q[DS_AW-1:0];
		ds_wdata = 64'd0;
		rs_we    = 1'b0;
		rs_waddr = rdp_q[RS_AW-1:0];
		rs_wdata = pc3;
		vs_we    = 1'b0;
		vs_waddr = opr_q[VS_AW-1:0];
		vs_wdata = top_q;

		case (st_q)
			ST_CLR: begin
				vs_we    = 1'b1;
				vs_waddr = clr_q;
				vs_wdata = 64'd0;
				if (clr_q == VS_AW'(VALUE_SLOTS - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					st_d     = ST_EXE;
					status_d = STAT_OK;
					rdval_d  = 64'd0;
				end
			end
			ST_EXE: begin
				st_d = ST_DONE;
				case (mode_t'(mode_q))
					MODE_EXEC: begin
						if (!stop_q) begin
							case (op_t'(op_q))
								OP_NOP: pc_d = pc1;
								OP_FETCH: begin
									if (idx_bad) begin
										stop_d   = 1'b1;
										status_d = STAT_BADIDX;
									end else if (ds_full) begin
										stop_d   = 1'b1;
										status_d = STAT_OVER;
									end else begin
										ds_we    = 1'b1;
										ds_wdata = vs_rdata;
										top_d    = vs_rdata;
										dd_d     = dd_q + DD_W'(1);
										pc_d     = pc3;
									end
								end
								OP_STORE: begin
									if (idx_bad) begin
										stop_d   = 1'b1;
										status_d = STAT_BADIDX;
									end else if (dd_q == '0) begin
										stop_d   = 1'b1;
										status_d = STAT_UNDER;
									end else begin
										vs_we = 1'b1;
										top_d = ds_rdata;
										dd_d  = dd_q - DD_W'(1);
										pc_d  = pc3;
									end
								end
								OP_LIT1, OP_LIT2, OP_LIT4: begin
									if (ds_full) begin
										stop_d   = 1'b1;
										status_d = STAT_OVER;
									end else begin
										ds_we = 1'b1;
										dd_d  = dd_q + DD_W'(1);
										if (op_t'(op_q) == OP_LIT1) begin
											ds_wdata = {56'd0, opr_q[7:0]};
											pc_d     = pc2;
										end else if (op_t'(op_q) == OP_LIT2) begin
											ds_wdata = {{48{opr_q[15]}}, opr_q[15:0]};
											pc_d     = pc3;
										end else begin
											ds_wdata = {{32{opr_q[31]}}, opr_q};
											pc_d     = pc5;
										end
										top_d = ds_wdata;
									end
								end
								OP_DROP: begin
									if (dd_q == '0) begin
										stop_d   = 1'b1;
										status_d = STAT_UNDER;
									end else begin
										top_d = ds_rdata;
										dd_d  = dd_q - DD_W'(1);
										pc_d  = pc1;
									end
								end
								OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_EQ: begin
									if (dd_q < DD_W'(2)) begin
										stop_d   = 1'b1;
										status_d = STAT_UNDER;
									end else begin
										st_d = ST_WB;
										case (op_t'(op_q))
											OP_ADD: arith_d = ds_rdata + top_q;
											OP_SUB: arith_d = ds_rdata - top_q;
											OP_LT: arith_d = {63'd0,
												$signed(ds_rdata) < $signed(top_q)};
											OP_GT: arith_d = {63'd0,
												$signed(top_q) < $signed(ds_rdata)};
											OP_EQ: arith_d = {63'd0, ds_rdata == top_q};
											OP_MUL: begin
												st_d    = ST_MUL;
												ma_d    = ds_rdata;
												mb_d    = top_q;
												macc_d  = 64'd0;
												itcnt_d = 6'd0;
											end
											OP_DIV: begin
												if (top_q == 64'd0) begin
													st_d     = ST_DONE;
													stop_d   = 1'b1;
													status_d = STAT_DIVZERO;
												end else begin
													st_d    = ST_DIV;
													dvd_d   = ua;
													dvs_d   = ub;
													rem_d   = 64'd0;
													dneg_d  = ds_rdata[63] ^ top_q[63];
													itcnt_d = 6'd0;
												end
											end
											default: arith_d = 64'd0;
										endcase
									end
								end
								OP_JZ, OP_JNZ: begin
									if (dd_q == '0) begin
										stop_d   = 1'b1;
										status_d = STAT_UNDER;
									end else begin
										top_d = ds_rdata;
										dd_d  = dd_q - DD_W'(1);
										if ((op_t'(op_q) == OP_JZ) == (top_q == 64'd0)) begin
											pc_d = target;
										end else begin
											pc_d = pc3;
										end
									end
								end
								OP_JMP: pc_d = target;
								OP_CALL: begin
									if (rs_full) begin
										stop_d   = 1'b1;
										status_d = STAT_RETOVER;
									end else begin
										rs_we = 1'b1;
										rdp_d = rdp_q + RD_W'(1);
										pc_d  = target;
									end
								end
								OP_RET: begin
									if (rdp_q == '0) begin
										pc_d     = pc1;
										stop_d   = 1'b1;
										status_d = STAT_EMPTYRET;
									end else begin
										pc_d  = rs_rdata;
										rdp_d = rdp_m1;
									end
								end
								OP_HALT: begin
									pc_d     = pc1;
									stop_d   = 1'b1;
									status_d = STAT_HALT;
								end
								default: begin
									pc_d     = pc1;
									stop_d   = 1'b1;
									status_d = STAT_BADOP;
								end
							endcase
						end
					end
					MODE_READ: begin
						if (opr_q < 32'(VALUE_SLOTS)) begin
							rdval_d = vs_rdata;
						end else begin
							status_d = STAT_BADIDX;
						end
					end
					MODE_RESTART: begin
						pc_d   = opr_q[PC_BITS-1:0];
						dd_d   = '0;
						rdp_d  = '0;
						stop_d = 1'b0;
					end
					default: ;
				endcase
			end
			ST_MUL: begin
				macc_d  = macc_nx;
				ma_d    = {ma_q[47:0], 16'd0};
				mb_d    = {16'd0, mb_q[63:16]};
				itcnt_d = itcnt_q + 6'd1;
				if (itcnt_q == 6'd3) begin
					arith_d = macc_nx;
					st_d    = ST_WB;
				end
			end
			ST_DIV: begin
				rem_d   = dtrial[64] ? dshift[63:0] : dtrial[63:0];
				dvd_d   = dvd_nx;
				itcnt_d = itcnt_q + 6'd1;
				if (itcnt_q == 6'd63) begin
					arith_d = dneg_q ? (64'd0 - dvd_nx) : dvd_nx;
					st_d    = ST_WB;
				end
			end
			ST_WB: begin
				// binary result replaces the two operands
				ds_we    = 1'b1;
				ds_waddr = dd_m2[DS_AW-1:0];
				ds_wdata = arith_q;
				top_d    = arith_q;
				dd_d     = dd_q - DD_W'(1);
				pc_d     = pc1;
				st_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			pc_q        <= '0;
			dd_q        <= '0;
			rdp_q       <= '0;
			stop_q      <= 1'b0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			pc_q   <= pc_d;
			dd_q   <= dd_d;
			rdp_q  <= rdp_d;
			stop_q <= stop_d;
			if (st_q == ST_CLR) begin
				clr_q <= clr_q + VS_AW'(1);
			end
			if (st_q == ST_DONE && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= cmd.mode;
			op_q   <= cmd.opcode;
			opr_q  <= cmd.operand;
		end
		top_q    <= top_d;
		status_q <= status_d;
		rdval_q  <= rdval_d;
		arith_q  <= arith_d;
		itcnt_q  <= itcnt_d;
		ma_q     <= ma_d;
		mb_q     <= mb_d;
		macc_q   <= macc_d;
		dvd_q    <= dvd_d;
		rem_q    <= rem_d;
		dvs_q    <= dvs_d;
		dneg_q   <= dneg_d;
		if (st_q == ST_DONE && (!res_valid_q || res_ready)) begin
			res_q.next_pc    <= pc_q;
			res_q.halted     <= stop_q;
			res_q.status     <= status_q;
			res_q.top_value  <= (dd_q == '0) ? 64'sd0 : $signed(top_q);
			res_q.read_value <= $signed(rdval_q);
		end
	end

`ifndef SYNTHESIS
	a_dd_range: assert property (@(posedge clk) disable iff (!arst_n)
		dd_q <= DD_W'(STACK_DEPTH))
		else $error("data depth beyond stack size");

	a_rdp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rdp_q <= RD_W'(RETURN_DEPTH))
		else $error("return depth beyond stack size");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (st_q == ST_EXE))
		else $error("accepted word not executed");

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(st_q == ST_DONE))
		else $error("result raised outside done state");

	a_no_write_at_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR) |-> (!ds_we && !rs_we && !cmd_ready))
		else $error("stack write or accept during clearing");
`endif
endmodule
